// File: rtl/core/nearest_clock_divider_picker_defines.svh
// Assertion macros used by the picker top level.
`ifndef NEAREST_CLOCK_DIVIDER_PICKER_DEFINES_SVH
`define NEAREST_CLOCK_DIVIDER_PICKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NCDP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ncdp check failed");

// Next-cycle implication, checked outside reset.
`define NCDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ncdp check failed");

`endif

// File: rtl/core/ncdp_pkg.sv
package ncdp_pkg;

  localparam int unsigned LadderLen = 34;
  localparam int unsigned IdxW      = $clog2(LadderLen);
  localparam int unsigned ReqW      = 32;
  localparam int unsigned HzW       = 29;
  localparam int unsigned CodeW     = 5;
  localparam int unsigned ProdW     = ReqW + 8;

  localparam logic [ReqW-1:0]  DefaultReqHz = 32'd20000000;
  localparam logic [ReqW-1:0]  FarAbsHz     = 32'd100000;
  localparam logic [ProdW-1:0] FarRelDiv    = 40'd200;

  typedef struct packed {
    logic             root;
    logic [CodeW-1:0] div_code;
    logic [HzW-1:0]   hz;
  } rung_t;

  typedef struct packed {
    logic             root;
    logic [CodeW-1:0] div_code;
    logic [HzW-1:0]   hz;
    logic             exact;
    logic             far;
  } pick_t;

  // Ladder, sorted by strictly falling frequency; div_code is divider - 1.
  function automatic rung_t rung(input logic [IdxW-1:0] idx);
    rung_t r;
    case (idx)
      6'd0:    r = '{1'b1, 5'd0,  29'd320000000};
      6'd1:    r = '{1'b0, 5'd0,  29'd240000000};
      6'd2:    r = '{1'b1, 5'd1,  29'd160000000};
      6'd3:    r = '{1'b0, 5'd1,  29'd120000000};
      6'd4:    r = '{1'b1, 5'd2,  29'd106666666};
      6'd5:    r = '{1'b0, 5'd2,  29'd80000000};
      6'd6:    r = '{1'b1, 5'd4,  29'd64000000};
      6'd7:    r = '{1'b0, 5'd3,  29'd60000000};
      6'd8:    r = '{1'b1, 5'd5,  29'd53333333};
      6'd9:    r = '{1'b0, 5'd4,  29'd48000000};
      6'd10:   r = '{1'b1, 5'd6,  29'd45714285};
      6'd11:   r = '{1'b0, 5'd5,  29'd40000000};
      6'd12:   r = '{1'b1, 5'd8,  29'd35555555};
      6'd13:   r = '{1'b0, 5'd6,  29'd34285714};
      6'd14:   r = '{1'b1, 5'd9,  29'd32000000};
      6'd15:   r = '{1'b0, 5'd7,  29'd30000000};
      6'd16:   r = '{1'b1, 5'd10, 29'd29090909};
      6'd17:   r = '{1'b0, 5'd8,  29'd26666666};
      6'd18:   r = '{1'b0, 5'd9,  29'd24000000};
      6'd19:   r = '{1'b1, 5'd13, 29'd22857142};
      6'd20:   r = '{1'b0, 5'd10, 29'd21818181};
      6'd21:   r = '{1'b0, 5'd11, 29'd20000000};
      6'd22:   r = '{1'b0, 5'd12, 29'd18461538};
      6'd23:   r = '{1'b0, 5'd13, 29'd17142857};
      6'd24:   r = '{1'b0, 5'd14, 29'd16000000};
      6'd25:   r = '{1'b0, 5'd15, 29'd15000000};
      6'd26:   r = '{1'b0, 5'd16, 29'd14117647};
      6'd27:   r = '{1'b0, 5'd17, 29'd13333333};
      6'd28:   r = '{1'b0, 5'd19, 29'd12000000};
      6'd29:   r = '{1'b0, 5'd20, 29'd11428571};
      6'd30:   r = '{1'b0, 5'd23, 29'd10000000};
      6'd31:   r = '{1'b0, 5'd25, 29'd9230769};
      6'd32:   r = '{1'b0, 5'd29, 29'd8000000};
      6'd33:   r = '{1'b0, 5'd31, 29'd7500000};
      default: r = '{1'b1, 5'd0,  29'd320000000};
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/nearest_clock_divider_picker.sv
// Nearest clock divider picker: each requested pixel clock (0 means 20 MHz)
// is matched to the closest rung of a fixed 34-entry ladder of 320 MHz and
// 240 MHz roots over integer dividers, ties going to the higher frequency.
// Two register stages (request register, result register): an accepted
// request is held in the request register, then its result word in the
// result register; one word is taken every cycle while the output side
// keeps up; the rung search is a bank of parallel constant compares. With
// clock_source set to 1 every result reports the PLL source and zero in the
// other fields. Write clock_source only while no word is in flight.
module nearest_clock_divider_picker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ncdp_pkg::ReqW-1:0] requested_hz_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      source_select_o,
  output logic                      root_select_o,
  output logic [ncdp_pkg::CodeW-1:0] divider_code_o,
  output logic [ncdp_pkg::HzW-1:0]  applied_hz_o,
  output logic                      exact_match_o,
  output logic                      far_warning_o
);
  import ncdp_pkg::*;
  `include "nearest_clock_divider_picker_defines.svh"

  logic            clock_source_q;
  logic            req_valid;
  logic [ReqW-1:0] req;
  pick_t           pick;
  logic            out_take;
  logic            out_valid_q;
  logic            out_valid_d;
  logic            source_q;
  pick_t           result_q;
  pick_t           result_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_source_q <= 1'b0;
    end else if (cfg_we_i) begin
      clock_source_q <= cfg_wdata_i;
    end
  end

  assign out_take = !out_valid_q || out_ready_i;

  ncdp_req_stage u_req_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .requested_hz_i (requested_hz_i),
    .take_i         (out_take),
    .valid_o        (req_valid),
    .req_o          (req)
  );

  ncdp_search u_search (
    .req_i  (req),
    .pick_o (pick)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = req_valid;
    end
  end

  // PLL source clears every ladder field.
  assign result_d = clock_source_q ? '0 : pick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && req_valid) begin
      source_q <= clock_source_q;
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign source_select_o = source_q;
  assign root_select_o   = result_q.root;
  assign divider_code_o  = result_q.div_code;
  assign applied_hz_o    = result_q.hz;
  assign exact_match_o   = result_q.exact;
  assign far_warning_o   = result_q.far;

  `NCDP_ASSERT_NOW(a_full_stall_blocks, clk_i, rst_ni,
    req_valid && out_valid_q && !out_ready_i, !in_ready_o)
  `NCDP_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni,
    in_valid_i && in_ready_o, req_valid)
  `NCDP_ASSERT_NOW(a_exact_not_far, clk_i, rst_ni,
    out_valid_q && exact_match_o, !far_warning_o && (applied_hz_o != '0 || source_q))

endmodule

// File: rtl/core/ncdp_req_stage.sv
module ncdp_req_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ncdp_pkg::ReqW-1:0] requested_hz_i,
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [ncdp_pkg::ReqW-1:0] req_o
);
  import ncdp_pkg::*;

  logic            valid_q;
  logic            valid_d;
  logic [ReqW-1:0] req_q;
  logic [ReqW-1:0] req_d;
  logic            load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // Zero request falls back to the default pixel clock.
  assign req_d = (requested_hz_i == '0) ? DefaultReqHz : requested_hz_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_d;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// File: rtl/core/ncdp_search.sv
module ncdp_search (
  input  logic [ncdp_pkg::ReqW-1:0] req_i,
  output ncdp_pkg::pick_t           pick_o
);
  import ncdp_pkg::*;

  logic [IdxW-1:0]  above_cnt;
  rung_t            scan_rung;
  logic [IdxW-1:0]  up_idx;
  logic [IdxW-1:0]  dn_idx;
  rung_t            up_rung;
  rung_t            dn_rung;
  logic [ReqW-1:0]  up_hz;
  logic [ReqW-1:0]  dn_hz;
  logic [ReqW-1:0]  up_diff;
  logic [ReqW-1:0]  dn_diff;
  logic             take_up;
  rung_t            best;
  logic [ReqW-1:0]  near_diff;
  logic [ProdW-1:0] diff_x200;

  // The ladder falls strictly, so the rungs above the request form a prefix.
  always_comb begin
    above_cnt = '0;
    scan_rung = rung('0);
    for (int i = 0; i < LadderLen; i++) begin
      scan_rung = rung(IdxW'(i));
      if (req_i < {{(ReqW-HzW){1'b0}}, scan_rung.hz}) begin
        above_cnt = IdxW'(i + 1);
      end
    end
  end

  assign up_idx = (above_cnt == '0) ? '0 : above_cnt - IdxW'(1);
  assign dn_idx = (above_cnt == IdxW'(LadderLen)) ? IdxW'(LadderLen - 1) : above_cnt;

  assign up_rung = rung(up_idx);
  assign dn_rung = rung(dn_idx);
  assign up_hz   = {{(ReqW-HzW){1'b0}}, up_rung.hz};
  assign dn_hz   = {{(ReqW-HzW){1'b0}}, dn_rung.hz};

  assign up_diff = (up_hz >= req_i) ? up_hz - req_i : req_i - up_hz;
  assign dn_diff = (dn_hz >= req_i) ? dn_hz - req_i : req_i - dn_hz;

  // Earlier rung wins a tie.
  assign take_up   = (up_diff <= dn_diff);
  assign best      = take_up ? up_rung : dn_rung;
  assign near_diff = take_up ? up_diff : dn_diff;

  // diff > req/200 (truncated) is the same as 200*diff > req.
  assign diff_x200 = {{(ProdW-ReqW){1'b0}}, near_diff} * FarRelDiv;

  always_comb begin
    pick_o.root     = best.root;
    pick_o.div_code = best.div_code;
    pick_o.hz       = best.hz;
    pick_o.exact    = (near_diff == '0);
    pick_o.far      = (near_diff > FarAbsHz) &&
                      (diff_x200 > {{(ProdW-ReqW){1'b0}}, req_i});
  end

endmodule
